/* src/sba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg: shared types and codes of the bitmap slot allocator
// Command and status codes, the slot row width and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package sba_pkg;

	// request kinds (carried on s_tuser)
	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	// result status codes (carried on m_tuser)
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOMEM = 2'd1;
	localparam logic [1:0] ST_NOKEY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// slots per bitmap row and the full-row mask
	localparam int         ROW_BITS = 8;
	localparam logic [7:0] ROW_ONES = 8'hFF;

	// quotient width of the slot count divider (size + SLOT_BYTES - 1 fits)
	localparam int DIV_W = 16;

	// controller to datapath
	typedef struct packed {
		logic       load_req;
		logic       is_alloc;
		logic       clr_run;
		logic       kscan_clr;
		logic       kscan_run;
		logic       div_init;
		logic       div_run;
		logic       bscan_clr;
		logic       bscan_run;
		logic       mark_init;
		logic       mark_run;
		logic       rec_write;
		logic       rec_drop;
		logic       out_load;
		logic [1:0] out_status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic kscan_done;
		logic hit;
		logic free_found;
		logic div_done;
		logic need_zero;
		logic need_big;
		logic bscan_done;
		logic bscan_found;
		logic mark_done;
		logic out_busy;
	} dp_sts_t;

endpackage

/* src/bitmap_slot_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator: first-fit slot allocator with keyed records
// Splits a code region into slots tracked by a used bitmap and keeps a
// record table of {key, first slot, slot count}; allocate, free and look up.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  cfg      | in        | cfg_wdata = region_base (write on cfg_we)
//  s_axis   | in        | tuser = command; tdata = key[31:0], size_bytes[46:32]
//  m_axis   | out       | tuser = status; tdata = address, first_slot, slot_count
//
// After reset a clearing pass zeroes the bitmap, one row of 8 slots a cycle;
// no request is taken until it ends. Each allocate, free or lookup scans the
// record table one entry at a time through its single read port; a new-key
// allocate then computes the slot count and, if it is nonzero, scans the
// bitmap row by row for a first fit and marks the run, reading each row that
// the run touches and then writing it back; a free clears its run the same
// way. One request at a time; the next is taken while the previous result
// waits in the output register.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
	parameter int SLOT_BYTES     = 16,
	parameter int NUM_SLOTS      = 1024,
	parameter int RECORD_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,   // region_base[31:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,     // command[1:0]
	input  logic [47:0] s_tdata,     // key[31:0], size_bytes[46:32], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,     // status[1:0]
	output logic [55:0] m_tdata      // address[31:0], first_slot[41:32], slot_count[52:42]
);

	sba_pkg::dp_cmd_t cmd;
	sba_pkg::dp_sts_t sts;

	sba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	sba_datapath #(
		.SLOT_BYTES     (SLOT_BYTES),
		.NUM_SLOTS      (NUM_SLOTS),
		.RECORD_ENTRIES (RECORD_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata)
	);

	// no transfer in before the bitmap clearing pass has ended
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> sts.clr_done)
		else $error("request taken during clearing pass");

	// a result is only loaded into an empty output register
	a_out_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !m_tvalid)
		else $error("result overwrote a pending transfer");

	// record insert and removal never in the same cycle
	a_rec_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rec_write && cmd.rec_drop))
		else $error("record write and drop together");

	// a record is written only after a key scan that found a free entry and no match
	a_rec_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rec_write |-> (sts.free_found && !sts.hit))
		else $error("record write without a free entry");

endmodule

/* src/sba_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_datapath: storage and arithmetic of the slot allocator
// Record table scan, slot count unit, first-fit bitmap scan, run
// mark/clear, region base register and the result register.
// ----------------------------------------------------------------------------
module sba_datapath #(
	parameter int SLOT_BYTES     = 16,
	parameter int NUM_SLOTS      = 1024,
	parameter int RECORD_ENTRIES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sba_pkg::dp_cmd_t cmd,
	output sba_pkg::dp_sts_t sts,
	input  logic [47:0]      in_data,   // key[31:0], size_bytes[46:32], pad
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [1:0]       m_tuser,   // status[1:0]
	output logic [55:0]      m_tdata    // address[31:0], first_slot[41:32], slot_count[52:42]
);

	localparam int ROWS   = (NUM_SLOTS + sba_pkg::ROW_BITS - 1) / sba_pkg::ROW_BITS;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BP_W   = $clog2(ROWS + 1);
	localparam int COL_W  = $clog2(sba_pkg::ROW_BITS);
	localparam int IDX_W  = ROW_W + COL_W;
	localparam int AW     = IDX_W + 1;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
	localparam int REC_W  = (RECORD_ENTRIES > 1) ? $clog2(RECORD_ENTRIES) : 1;
	localparam int RP_W   = $clog2(RECORD_ENTRIES + 1);
	localparam int REC_DW = 32 + SLOT_W + CNT_W;

	// request and configuration registers
	logic [31:0] key_q;
	logic [14:0] size_q;
	logic [31:0] base_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q  <= in_data[31:0];
			size_q <= in_data[46:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// ---------------- record table ----------------
	logic [RECORD_ENTRIES-1:0] rvalid_q;
	logic [REC_DW-1:0]         rmem [RECORD_ENTRIES];
	logic [REC_DW-1:0]         krd_s1;
	logic [RP_W-1:0]           kptr_q;
	logic                      kv_s1, kvld_s1;
	logic [REC_W-1:0]          kidx_s1;
	logic                      hit_q, ffree_q;
	logic [REC_W-1:0]          hit_idx_q, free_idx_q;
	logic [SLOT_W-1:0]         hit_first_q;
	logic [CNT_W-1:0]          hit_len_q;
	logic [SLOT_W-1:0]         alloc_first;
	logic [CNT_W-1:0]          need_c;

	// record memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.rec_write) begin
			rmem[free_idx_q] <= {key_q, alloc_first, need_c};
		end
		krd_s1 <= rmem[kptr_q[REC_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= '0;
		end else if (cmd.rec_write) begin
			rvalid_q[free_idx_q] <= 1'b1;
		end else if (cmd.rec_drop) begin
			rvalid_q[hit_idx_q] <= 1'b0;
		end
	end

	// key scan: one entry per cycle, first match and first free entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kptr_q      <= '0;
			kv_s1       <= 1'b0;
			kvld_s1     <= 1'b0;
			kidx_s1     <= '0;
			hit_q       <= 1'b0;
			ffree_q     <= 1'b0;
			hit_idx_q   <= '0;
			free_idx_q  <= '0;
			hit_first_q <= '0;
			hit_len_q   <= '0;
		end else if (cmd.kscan_clr) begin
			kptr_q  <= '0;
			kv_s1   <= 1'b0;
			hit_q   <= 1'b0;
			ffree_q <= 1'b0;
		end else if (cmd.kscan_run) begin
			if (kptr_q < RP_W'(RECORD_ENTRIES)) begin
				kv_s1   <= 1'b1;
				kvld_s1 <= rvalid_q[kptr_q[REC_W-1:0]];
				kidx_s1 <= kptr_q[REC_W-1:0];
				kptr_q  <= kptr_q + 1'b1;
			end else begin
				kv_s1 <= 1'b0;
			end
			if (kv_s1) begin
				if (kvld_s1 && krd_s1[REC_DW-1 -: 32] == key_q && !hit_q) begin
					hit_q       <= 1'b1;
					hit_idx_q   <= kidx_s1;
					hit_first_q <= krd_s1[CNT_W +: SLOT_W];
					hit_len_q   <= krd_s1[CNT_W-1:0];
				end
				if (!kvld_s1 && !ffree_q) begin
					ffree_q    <= 1'b1;
					free_idx_q <= kidx_s1;
				end
			end
		end
	end

	// ---------------- slot count: ceil(size / SLOT_BYTES) ----------------
	// (size + SLOT_BYTES - 1) times a reciprocal scaled by 2^32, then >> 32;
	// exact for any 16-bit dividend and divisor up to 4096
	localparam logic [32:0] RCP_M =
		33'(((64'd1 << 32) + 64'(SLOT_BYTES) - 64'd1) / 64'(SLOT_BYTES));

	logic [sba_pkg::DIV_W-1:0]  num_q;
	logic [sba_pkg::DIV_W-1:0]  quo_q;
	logic                       dvalid_q;
	logic [sba_pkg::DIV_W+32:0] prod;
	logic                       div_done;

	assign prod     = {33'd0, num_q} * {{sba_pkg::DIV_W{1'b0}}, RCP_M};
	assign div_done = dvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q    <= '0;
			quo_q    <= '0;
			dvalid_q <= 1'b0;
		end else if (cmd.div_init) begin
			num_q    <= sba_pkg::DIV_W'(size_q) + sba_pkg::DIV_W'(SLOT_BYTES - 1);
			dvalid_q <= 1'b0;
		end else if (cmd.div_run && !dvalid_q) begin
			quo_q    <= prod[32 +: sba_pkg::DIV_W];
			dvalid_q <= 1'b1;
		end
	end

	logic need_zero, need_big;
	assign need_zero = quo_q == '0;
	assign need_big  = {1'b0, quo_q} > (sba_pkg::DIV_W + 1)'(NUM_SLOTS);
	assign need_c    = CNT_W'(quo_q);

	// ---------------- slot bitmap ----------------
	logic [sba_pkg::ROW_BITS-1:0] bmap [ROWS];
	logic [sba_pkg::ROW_BITS-1:0] brd_s1;
	logic [BP_W-1:0]              bptr_q;
	logic                         bv_s1;
	logic [ROW_W-1:0]             brow_s1;
	logic [CNT_W-1:0]             run_q;
	logic                         bfound_q;
	logic [SLOT_W-1:0]            bfirst_q;
	logic [BP_W-1:0]              clr_ptr_q;
	logic                         clr_done;
	logic [ROW_W-1:0]             mrow_q;
	logic [IDX_W-1:0]             mfirst_q, mlast_q;
	logic                         mph_q, mdone_q;
	logic [ROW_W-1:0]             rd_row;
	logic [sba_pkg::ROW_BITS-1:0] mmask, wdata;

	assign rd_row   = cmd.mark_run ? mrow_q : bptr_q[ROW_W-1:0];
	assign clr_done = clr_ptr_q == BP_W'(ROWS);

	// bitmap memory: clearing pass or run update, one registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_run && !clr_done) begin
			bmap[clr_ptr_q[ROW_W-1:0]] <= '0;
		end else if (cmd.mark_run && mph_q && !mdone_q) begin
			bmap[mrow_q] <= wdata;
		end
		brd_s1 <= bmap[rd_row];
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (cmd.clr_run && !clr_done) begin
			clr_ptr_q <= clr_ptr_q + 1'b1;
		end
	end

	// first-fit search over one row: run length carried across rows
	logic [CNT_W-1:0]  run_c;
	logic              fnd_c;
	logic [SLOT_W-1:0] first_c;

	always_comb begin
		logic [IDX_W-1:0] slot;
		logic             used;
		run_c   = run_q;
		fnd_c   = 1'b0;
		first_c = '0;
		for (int j = 0; j < sba_pkg::ROW_BITS; j++) begin
			slot  = {brow_s1, COL_W'(j)};
			used  = brd_s1[j] || ({1'b0, slot} >= AW'(NUM_SLOTS));
			run_c = used ? '0 : run_c + 1'b1;
			if (!fnd_c && run_c == need_c) begin
				fnd_c   = 1'b1;
				first_c = SLOT_W'(AW'(slot) + AW'(1) - AW'(need_c));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bptr_q   <= '0;
			bv_s1    <= 1'b0;
			brow_s1  <= '0;
			run_q    <= '0;
			bfound_q <= 1'b0;
			bfirst_q <= '0;
		end else if (cmd.bscan_clr) begin
			bptr_q   <= '0;
			bv_s1    <= 1'b0;
			run_q    <= '0;
			bfound_q <= 1'b0;
		end else if (cmd.bscan_run) begin
			if (bptr_q < BP_W'(ROWS) && !bfound_q) begin
				bv_s1   <= 1'b1;
				brow_s1 <= bptr_q[ROW_W-1:0];
				bptr_q  <= bptr_q + 1'b1;
			end else begin
				bv_s1 <= 1'b0;
			end
			if (bv_s1 && !bfound_q) begin
				run_q <= run_c;
				if (fnd_c) begin
					bfound_q <= 1'b1;
					bfirst_q <= first_c;
				end
			end
		end
	end

	assign alloc_first = need_zero ? '0 : bfirst_q;

	// run update: read a row, then write it back with the run bits set or cleared
	logic [SLOT_W-1:0] rng_first;
	logic [CNT_W-1:0]  rng_cnt;

	assign rng_first = cmd.is_alloc ? bfirst_q : hit_first_q;
	assign rng_cnt   = cmd.is_alloc ? need_c : hit_len_q;

	always_comb begin
		logic [IDX_W-1:0] slot;
		for (int j = 0; j < sba_pkg::ROW_BITS; j++) begin
			slot     = {mrow_q, COL_W'(j)};
			mmask[j] = (slot >= mfirst_q) && (slot <= mlast_q);
		end
		wdata = cmd.is_alloc ? (brd_s1 | mmask) : (brd_s1 & (sba_pkg::ROW_ONES & ~mmask));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrow_q   <= '0;
			mfirst_q <= '0;
			mlast_q  <= '0;
			mph_q    <= 1'b0;
			mdone_q  <= 1'b0;
		end else if (cmd.mark_init) begin
			mrow_q   <= ROW_W'(rng_first >> COL_W);
			mfirst_q <= IDX_W'(rng_first);
			mlast_q  <= IDX_W'(AW'(rng_first) + AW'(rng_cnt) - AW'(1));
			mph_q    <= 1'b0;
			mdone_q  <= rng_cnt == '0;
		end else if (cmd.mark_run && !mdone_q) begin
			if (!mph_q) begin
				mph_q <= 1'b1;
			end else begin
				mph_q <= 1'b0;
				if (ROW_W'(mlast_q >> COL_W) == mrow_q) begin
					mdone_q <= 1'b1;
				end else begin
					mrow_q <= mrow_q + 1'b1;
				end
			end
		end
	end

	// ---------------- result register ----------------
	logic [SLOT_W-1:0] res_first;
	logic [CNT_W-1:0]  res_cnt;
	logic [31:0]       res_addr;
	logic              m_tvalid_q;
	logic [1:0]        m_tuser_q;
	logic [55:0]       m_tdata_q;

	assign res_first = hit_q ? hit_first_q : alloc_first;
	assign res_cnt   = hit_q ? hit_len_q : need_c;
	assign res_addr  = base_q + 32'(32'(res_first) * 32'(SLOT_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tuser_q <= cmd.out_status;
			if (cmd.out_status == sba_pkg::ST_OK) begin
				m_tdata_q <= {3'b000, 11'(res_cnt), 10'(res_first), res_addr};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

	// status back to the controller
	assign sts.clr_done    = clr_done;
	assign sts.kscan_done  = (kptr_q == RP_W'(RECORD_ENTRIES)) && !kv_s1;
	assign sts.hit         = hit_q;
	assign sts.free_found  = ffree_q;
	assign sts.div_done    = div_done;
	assign sts.need_zero   = need_zero;
	assign sts.need_big    = need_big;
	assign sts.bscan_done  = bfound_q || ((bptr_q == BP_W'(ROWS)) && !bv_s1);
	assign sts.bscan_found = bfound_q;
	assign sts.mark_done   = mdone_q;
	assign sts.out_busy    = m_tvalid_q;

endmodule

/* src/sba_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_ctrl: request sequencer of the slot allocator
// One-hot state machine that steps the datapath through clear, key scan,
// divide, first-fit scan, run update and result delivery.
// ----------------------------------------------------------------------------
module sba_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       s_tuser,
	output sba_pkg::dp_cmd_t cmd,
	input  sba_pkg::dp_sts_t sts
);

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_KSCAN = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_BSCAN = 7'b0010000,
		S_MARK  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cmd_q, cmd_d;
	logic [1:0] status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			cmd_q    <= sba_pkg::CMD_NONE;
			status_q <= sba_pkg::ST_OK;
		end else begin
			state_q  <= state_d;
			cmd_q    <= cmd_d;
			status_q <= status_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d        = state_q;
		cmd_d          = cmd_q;
		status_d       = status_q;
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.is_alloc   = cmd_q == sba_pkg::CMD_ALLOC;
		cmd.out_status = status_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					cmd_d        = s_tuser;
					if (s_tuser != sba_pkg::CMD_NONE) begin
						cmd.kscan_clr = 1'b1;
						state_d       = S_KSCAN;
					end
				end
			end
			S_KSCAN: begin
				cmd.kscan_run = 1'b1;
				if (sts.kscan_done) begin
					if (cmd_q == sba_pkg::CMD_ALLOC) begin
						if (sts.hit) begin
							status_d = sba_pkg::ST_OK;
							state_d  = S_RESP;
						end else if (!sts.free_found) begin
							status_d = sba_pkg::ST_FULL;
							state_d  = S_RESP;
						end else begin
							cmd.div_init = 1'b1;
							state_d      = S_DIV;
						end
					end else if (!sts.hit) begin
						status_d = sba_pkg::ST_NOKEY;
						state_d  = S_RESP;
					end else if (cmd_q == sba_pkg::CMD_FREE) begin
						cmd.mark_init = 1'b1;
						state_d       = S_MARK;
					end else begin
						status_d = sba_pkg::ST_OK;
						state_d  = S_RESP;
					end
				end
			end
			S_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_done) begin
					if (sts.need_zero) begin
						cmd.rec_write = 1'b1;
						status_d      = sba_pkg::ST_OK;
						state_d       = S_RESP;
					end else if (sts.need_big) begin
						status_d = sba_pkg::ST_NOMEM;
						state_d  = S_RESP;
					end else begin
						cmd.bscan_clr = 1'b1;
						state_d       = S_BSCAN;
					end
				end
			end
			S_BSCAN: begin
				cmd.bscan_run = 1'b1;
				if (sts.bscan_done) begin
					if (sts.bscan_found) begin
						cmd.mark_init = 1'b1;
						state_d       = S_MARK;
					end else begin
						status_d = sba_pkg::ST_NOMEM;
						state_d  = S_RESP;
					end
				end
			end
			S_MARK: begin
				cmd.mark_run = 1'b1;
				if (sts.mark_done) begin
					if (cmd_q == sba_pkg::CMD_ALLOC) begin
						cmd.rec_write = 1'b1;
					end else begin
						cmd.rec_drop = 1'b1;
					end
					status_d = sba_pkg::ST_OK;
					state_d  = S_RESP;
				end
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* dv/bitmap_slot_allocator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_checker: result predictor and scoreboard
// Watches the config port and both stream channels, keeps its own copy of
// the slot bitmap and record table, and compares every result transfer.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_checker #(
	parameter int SLOT_BYTES     = 16,
	parameter int NUM_SLOTS      = 1024,
	parameter int RECORD_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [1:0]  s_tuser,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [1:0]  m_tuser,
	input  logic [55:0] m_tdata,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] address;
		logic [9:0]  first_slot;
		logic [10:0] slot_count;
	} alloc_reply_t;

	logic [31:0]  base_addr;
	logic         slot_busy [NUM_SLOTS];
	logic         rec_live  [RECORD_ENTRIES];
	logic [31:0]  rec_key   [RECORD_ENTRIES];
	logic [9:0]   rec_first [RECORD_ENTRIES];
	logic [10:0]  rec_len   [RECORD_ENTRIES];
	alloc_reply_t reply_q[$];

	assign pending = reply_q.size();

	function automatic alloc_reply_t make_reply(logic [1:0] st, int first, int count);
		alloc_reply_t r;
		r = '0;
		r.status = st;
		if (st == sba_pkg::ST_OK) begin
			r.address    = base_addr + 32'(first) * 32'(SLOT_BYTES);
			r.first_slot = 10'(first);
			r.slot_count = 11'(count);
		end
		return r;
	endfunction

	// apply one request to the model state, queue its reply
	task automatic predict_request(logic [1:0] cmd, logic [31:0] key, logic [14:0] size);
		int hit, spare, need, run, first;
		bit found;
		hit = -1;
		spare = -1;
		for (int e = 0; e < RECORD_ENTRIES; e++) begin
			if (rec_live[e] && rec_key[e] == key && hit < 0) hit = e;
			if (!rec_live[e] && spare < 0) spare = e;
		end
		if (cmd == sba_pkg::CMD_ALLOC) begin
			if (hit >= 0) begin
				reply_q.push_back(make_reply(sba_pkg::ST_OK, rec_first[hit], rec_len[hit]));
			end else if (spare < 0) begin
				reply_q.push_back(make_reply(sba_pkg::ST_FULL, 0, 0));
			end else begin
				need = (int'(size) + SLOT_BYTES - 1) / SLOT_BYTES;
				found = (need == 0);
				first = 0;
				run = 0;
				if (need > 0 && need <= NUM_SLOTS) begin
					for (int i = 0; i < NUM_SLOTS && !found; i++) begin
						run = slot_busy[i] ? 0 : run + 1;
						if (run == need) begin
							first = i + 1 - need;
							found = 1;
						end
					end
				end
				if (!found) begin
					reply_q.push_back(make_reply(sba_pkg::ST_NOMEM, 0, 0));
				end else begin
					for (int i = 0; i < need; i++) slot_busy[first + i] = 1'b1;
					rec_live[spare]  = 1'b1;
					rec_key[spare]   = key;
					rec_first[spare] = 10'(first);
					rec_len[spare]   = 11'(need);
					reply_q.push_back(make_reply(sba_pkg::ST_OK, first, need));
				end
			end
		end else if (cmd == sba_pkg::CMD_FREE || cmd == sba_pkg::CMD_LOOKUP) begin
			if (hit < 0) begin
				reply_q.push_back(make_reply(sba_pkg::ST_NOKEY, 0, 0));
			end else begin
				if (cmd == sba_pkg::CMD_FREE) begin
					for (int i = 0; i < rec_len[hit]; i++)
						if (rec_first[hit] + i < NUM_SLOTS) slot_busy[rec_first[hit] + i] = 1'b0;
					rec_live[hit] = 1'b0;
				end
				reply_q.push_back(make_reply(sba_pkg::ST_OK, rec_first[hit], rec_len[hit]));
			end
		end
	endtask

	// sample at rising edge: config, request and result transfers
	always @(posedge clk or negedge arst_n) begin
		alloc_reply_t want, got;
		if (!arst_n) begin
			base_addr = '0;
			fail_count = 0;
			reply_q.delete();
			for (int i = 0; i < NUM_SLOTS; i++) slot_busy[i] = 1'b0;
			for (int e = 0; e < RECORD_ENTRIES; e++) rec_live[e] = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status     = m_tuser;
				got.address    = m_tdata[31:0];
				got.first_slot = m_tdata[41:32];
				got.slot_count = m_tdata[52:42];
				if (reply_q.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (got.status != want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.address != want.address) begin
						$error("address: expected %h, actual %h", want.address, got.address);
						fail_count++;
					end
					if (got.first_slot != want.first_slot) begin
						$error("first_slot: expected %0d, actual %0d",
							want.first_slot, got.first_slot);
						fail_count++;
					end
					if (got.slot_count != want.slot_count) begin
						$error("slot_count: expected %0d, actual %0d",
							want.slot_count, got.slot_count);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata[31:0], s_tdata[46:32]);
			if (cfg_we) base_addr = cfg_wdata;
		end
	end

endmodule

/* dv/bitmap_slot_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_tb: stimulus and verdict for the slot allocator
// Directed corner requests, then random allocate/free/lookup traffic over a
// small key pool, under several region bases and idle patterns.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_tb;

	localparam int  RANDOM_ITEMS = 1400;
	localparam longint CYCLE_LIMIT = 5000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser = sba_pkg::CMD_NONE;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [1:0]  m_tuser;
	logic [55:0] m_tdata;
	int          fail_count;
	int          pending;
	int          send_idle_pct = 21;
	int          recv_idle_pct = 58;
	bit          recv_hold = 1'b0;
	longint      cycle_count = 0;
	logic [31:0] key_pool [16];

	bitmap_slot_allocator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
	);

	bitmap_slot_allocator_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (!arst_n || recv_hold) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one request transfer, random gap first; tvalid stays up for a back-to-back item
	task automatic send_request(logic [1:0] cmd, logic [31:0] key, logic [14:0] size);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, size, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_base(logic [31:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly small sizes, sometimes huge or exact multiples
	function automatic logic [14:0] pick_size();
		case ($urandom_range(9))
			0:       return 15'($urandom_range(16384));
			1:       return 15'($urandom_range(32767));
			2:       return 15'(16 * $urandom_range(8));
			default: return 15'($urandom_range(200));
		endcase
	endfunction

	function automatic logic [1:0] pick_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 45) return sba_pkg::CMD_ALLOC;
		if (r < 80) return sba_pkg::CMD_FREE;
		if (r < 98) return sba_pkg::CMD_LOOKUP;
		return sba_pkg::CMD_NONE;
	endfunction

	initial begin
		logic [31:0] k;
		for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_base(32'hFFFF_FF00);

		// directed corners
		send_request(sba_pkg::CMD_LOOKUP, 32'h1234, 15'd0);
		send_request(sba_pkg::CMD_FREE, 32'h1234, 15'd0);
		send_request(sba_pkg::CMD_ALLOC, 32'h0, 15'd0);
		send_request(sba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 15'd1);
		send_request(sba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 15'd999);
		send_request(sba_pkg::CMD_ALLOC, 32'h10, 15'd16);
		send_request(sba_pkg::CMD_ALLOC, 32'h11, 15'd17);
		send_request(sba_pkg::CMD_ALLOC, 32'h12, 15'd16384);
		send_request(sba_pkg::CMD_ALLOC, 32'h13, 15'h7FFF);
		send_request(sba_pkg::CMD_FREE, 32'h10, 15'd0);
		send_request(sba_pkg::CMD_ALLOC, 32'h14, 15'd8);
		send_request(sba_pkg::CMD_NONE, 32'h14, 15'h7FFF);
		send_request(sba_pkg::CMD_LOOKUP, 32'h11, 15'd0);
		send_request(sba_pkg::CMD_FREE, 32'hFFFF_FFFF, 15'd0);
		send_request(sba_pkg::CMD_FREE, 32'h0, 15'd0);
		send_request(sba_pkg::CMD_ALLOC, 32'h15, 15'd16336);
		send_request(sba_pkg::CMD_FREE, 32'h15, 15'd0);
		// fill the record table, then four more
		for (int i = 0; i < 66; i++) send_request(sba_pkg::CMD_ALLOC, 32'h100 + i, 15'd0);
		for (int i = 0; i < 66; i++) send_request(sba_pkg::CMD_FREE, 32'h100 + i, 15'd0);
		send_request(sba_pkg::CMD_FREE, 32'h11, 15'd0);
		send_request(sba_pkg::CMD_FREE, 32'h14, 15'd0);

		// random phases over bases and idle patterns
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 500) begin
				write_base(32'h0);
				send_idle_pct = 58;
				recv_idle_pct = 21;
			end
			if (n == 1000) begin
				write_base($urandom());
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n == 700) begin
				// long receiver hold while requests keep coming
				fork
					begin
						recv_hold = 1'b1;
						repeat (2000) @(negedge clk);
						recv_hold = 1'b0;
					end
				join_none
			end
			if (n == 1300) wait_drained();
			if ($urandom_range(19) == 0) k = $urandom();
			else k = key_pool[$urandom_range(15)];
			send_request(pick_cmd(), k, pick_size());
		end

		wait_drained();
		if (fail_count == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule

/* files.f */
src/sba_pkg.sv
src/sba_datapath.sv
src/sba_ctrl.sv
src/bitmap_slot_allocator.sv
dv/bitmap_slot_allocator_checker.sv
dv/bitmap_slot_allocator_tb.sv
